// ===== rtl/core/oaht_pkg.sv =====
package oaht_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = IDX_W + 1;
    localparam int KEY_BYTES   = 8;
    localparam int KEY_W       = 8 * KEY_BYTES;
    localparam int LEN_W       = 4;
    localparam int VAL_W       = 32;
    localparam int DIST_W      = 6;
    localparam int COLL_W      = 32;
    localparam int CFG_W       = 10;
    localparam int CFG_IDX_W   = 3;

    // modulo reducer: dividend width, shift count width, shifted divisor width
    localparam int RED_W    = 16;
    localparam int RED_SH_W = 4;
    localparam int DSH_W    = RED_W + SIZE_W;

    localparam logic [RED_W-1:0] HASH_SEED = RED_W'(5381);
    localparam logic [RED_W-1:0] MUL_A     = RED_W'(31);
    localparam logic [RED_W-1:0] MUL_B     = RED_W'(37);

    // start shifts: dividend is known to stay below divisor << (shift + 1)
    localparam logic [RED_SH_W-1:0] SH_SEED = RED_SH_W'(12);
    localparam logic [RED_SH_W-1:0] SH_BYTE = RED_SH_W'(7);
    localparam logic [RED_SH_W-1:0] SH_STEP = RED_SH_W'(10);
    localparam logic [RED_SH_W-1:0] SH_LIN  = RED_SH_W'(15);
    localparam logic [RED_SH_W-1:0] SH_SQ   = RED_SH_W'(9);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    localparam logic [1:0] PM_DOUBLE = 2'd0;
    localparam logic [1:0] PM_CUSTOM = 2'd1;
    localparam logic [1:0] PM_ROBIN  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_METHOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_SELECT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_COEFF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_COEFF = 3'd4;

    typedef enum logic [2:0] {
        STAT_OK    = 3'd0,
        STAT_DUP   = 3'd1,
        STAT_FULL  = 3'd2,
        STAT_MISS  = 3'd3,
        STAT_UNSUP = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_WAIT,
        ST_READ,
        ST_CHECK,
        ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        PH_SEED,
        PH_BYTE,
        PH_STEP,
        PH_LIN,
        PH_SQ
    } phase_t;

    typedef struct packed {
        logic              start;
        logic [RED_W-1:0]  value;
        logic [SIZE_W-1:0] divisor;
        logic [RED_SH_W-1:0] shift;
    } red_req_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
        logic [VAL_W-1:0] value;
    } slot_entry_t;

endpackage

// ===== rtl/core/oaht_reduce.sv =====
module oaht_reduce
    import oaht_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  red_req_t         req,
    output logic             done,
    output logic [RED_W-1:0] rem
);

    logic [RED_W-1:0]    rem_reg, rem_next;
    logic [DSH_W-1:0]    dsh_reg, dsh_next;
    logic [RED_SH_W-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DSH_W-1:0]    rem_wide;

    always_comb
    begin
        rem_wide  = DSH_W'(rem_reg);
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = req.value;
            dsh_next  = DSH_W'(req.divisor) << req.shift;
            cnt_next  = req.shift;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // one restoring subtract per cycle
            if (rem_wide >= dsh_reg)
            begin
                rem_next = RED_W'(rem_wide - dsh_reg);
            end
            dsh_next = dsh_reg >> 1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/core/oaht_slot_ram.sv =====
module oaht_slot_ram
    import oaht_pkg::*;
(
    input  logic              clk,
    input  logic [IDX_W-1:0]  rd_addr,
    output slot_entry_t       rd_entry,
    output logic [DIST_W-1:0] rd_dist,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic              we_entry,
    input  slot_entry_t       wr_entry,
    input  logic              we_dist,
    input  logic [DIST_W-1:0] wr_dist
);

    slot_entry_t       entry_mem [TABLE_DEPTH];
    logic [DIST_W-1:0] dist_mem  [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we_entry)
        begin
            entry_mem[wr_addr] <= wr_entry;
        end
        if (we_dist)
        begin
            dist_mem[wr_addr] <= wr_dist;
        end
        rd_entry <= entry_mem[rd_addr];
        rd_dist  <= dist_mem[rd_addr];
    end

endmodule

// ===== rtl/core/open_addressing_hash_table_core.sv =====
// Channel   Direction  Handshake             Payload
// request   in         req_valid / req_stall opcode, key_bytes, key_length, value
// result    out        res_valid / res_stall status, probe_count, collision_total
// config    in         cfg_we                cfg_index, cfg_data
//
// One request at a time. Hashing runs one shared restoring modulo unit in
// turn for the base-37 seed, each key byte and, where the probe method needs
// them, the step and the custom-probe coefficients. Each probe then takes a
// slot memory read followed by a check and write. An unsupported request goes
// straight to the finish state.
// Reset empties every slot at once through per-slot flags; no clearing pass.
// A finished result waits in the output register, so a new request is taken
// while res_stall holds it.
module open_addressing_hash_table_core
    import oaht_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  logic [1:0]              opcode,
    input  logic [KEY_W-1:0]        key_bytes,
    input  logic [LEN_W-1:0]        key_length,
    input  logic signed [VAL_W-1:0] value,
    output logic                    res_valid,
    input  logic                    res_stall,
    output logic [2:0]              status,
    output logic [SIZE_W-1:0]       probe_count,
    output logic [COLL_W-1:0]       collision_total
);

    // configuration
    logic [1:0]        probe_method_reg;
    logic              hash_select_reg;
    logic [6:0]        table_size_reg;
    logic [CFG_W-1:0]  linear_coeff_reg;
    logic [CFG_W-1:0]  square_coeff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_method_reg <= PM_ROBIN;
            hash_select_reg  <= 1'b0;
            table_size_reg   <= 7'd13;
            linear_coeff_reg <= '0;
            square_coeff_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PROBE_METHOD: probe_method_reg <= cfg_data[1:0];
                CFG_HASH_SELECT:  hash_select_reg  <= cfg_data[0];
                CFG_TABLE_SIZE:   table_size_reg   <= cfg_data[6:0];
                CFG_LINEAR_COEFF: linear_coeff_reg <= cfg_data;
                CFG_SQUARE_COEFF: square_coeff_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    logic [SIZE_W-1:0] n_size;

    always_comb
    begin
        if (table_size_reg < 7'd2)
            n_size = SIZE_W'(2);
        else if (SIZE_W'(table_size_reg) > SIZE_W'(TABLE_DEPTH) || table_size_reg > 7'd64)
            n_size = SIZE_W'(TABLE_DEPTH);
        else
            n_size = SIZE_W'(table_size_reg);
    end

    function automatic logic [IDX_W-1:0] mod_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b,
                                                input logic [SIZE_W-1:0] n);
        logic [SIZE_W:0] s;
        s = (SIZE_W+1)'(a) + (SIZE_W+1)'(b);
        if (s >= (SIZE_W+1)'(n))
            s = s - (SIZE_W+1)'(n);
        return IDX_W'(s);
    endfunction

    // registers
    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic [1:0]         op_reg, op_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [VAL_W-1:0]   val_reg, val_next;
    logic [2:0]         byte_idx_reg, byte_idx_next;
    logic [IDX_W-1:0]   h_reg, h_next;
    logic [IDX_W-1:0]   step_reg, step_next;
    logic [IDX_W-1:0]   lin_reg, lin_next;
    logic [IDX_W-1:0]   sq_reg, sq_next;
    logic [IDX_W-1:0]   sq2_reg, sq2_next;
    logic [IDX_W-1:0]   acc_lin_reg, acc_lin_next;
    logic [IDX_W-1:0]   acc_sq_reg, acc_sq_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [SIZE_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]   tomb_idx_reg, tomb_idx_next;
    logic               have_tomb_reg, have_tomb_next;
    logic               seen_reg, seen_next;
    logic               displaced_reg, displaced_next;
    logic               full_reg, full_next;
    logic [SIZE_W-1:0]  dist_reg, dist_next;
    logic [TABLE_DEPTH-1:0] empty_reg, empty_next;
    logic [TABLE_DEPTH-1:0] tomb_reg, tomb_next;
    logic [COLL_W-1:0]  coll_reg, coll_next;
    status_t            fin_status_reg, fin_status_next;
    logic [SIZE_W-1:0]  fin_probe_reg, fin_probe_next;
    logic               res_valid_reg, res_valid_next;
    logic [2:0]         res_status_reg, res_status_next;
    logic [SIZE_W-1:0]  res_probe_reg, res_probe_next;
    logic [COLL_W-1:0]  res_coll_reg, res_coll_next;

    // reducer and memory
    red_req_t           red_req;
    logic               red_done;
    logic [RED_W-1:0]   red_rem;
    slot_entry_t        rd_entry;
    logic [DIST_W-1:0]  rd_dist;
    logic [IDX_W-1:0]   wr_addr;
    logic               we_entry;
    slot_entry_t        wr_entry;
    logic               we_dist;
    logic [DIST_W-1:0]  wr_dist;

    oaht_reduce u_reduce (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (red_req),
        .done  (red_done),
        .rem   (red_rem)
    );

    oaht_slot_ram u_slot_ram (
        .clk      (clk),
        .rd_addr  (idx_reg),
        .rd_entry (rd_entry),
        .rd_dist  (rd_dist),
        .wr_addr  (wr_addr),
        .we_entry (we_entry),
        .wr_entry (wr_entry),
        .we_dist  (we_dist),
        .wr_dist  (wr_dist)
    );

    // helper terms
    logic [LEN_W-1:0]   len_in;
    logic [KEY_W-1:0]   key_in;
    logic               supported;
    logic [10:0]        byte_sum;
    logic [TABLE_DEPTH-1:0] free_in;
    logic               no_free;
    logic [IDX_W-1:0]   rem_idx;
    logic               key_hit;
    logic               slot_empty;
    logic               slot_tomb;
    logic [IDX_W-1:0]   lin_step;
    logic [IDX_W-1:0]   sq_step;
    logic [IDX_W-1:0]   sq2_step;
    logic [IDX_W-1:0]   next_probe;
    logic [IDX_W-1:0]   next_linear;
    logic [IDX_W-1:0]   ins_addr;
    logic [RED_W-1:0]   hash_mul;

    always_comb
    begin
        if (key_length == '0)
            len_in = LEN_W'(1);
        else if (key_length > LEN_W'(KEY_BYTES))
            len_in = LEN_W'(KEY_BYTES);
        else
            len_in = key_length;
        for (int b = 0; b < KEY_BYTES; b++)
        begin
            key_in[b*8 +: 8] = (LEN_W'(b) < len_in) ? key_bytes[b*8 +: 8] : 8'd0;
        end
        byte_sum = '0;
        for (int b = 0; b < KEY_BYTES; b++)
        begin
            byte_sum = byte_sum + 11'(key_reg[b*8 +: 8]);
        end
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            free_in[i] = (empty_reg[i] | tomb_reg[i]) && (SIZE_W'(i) < n_size);
        end
    end

    assign supported = ((probe_method_reg == PM_DOUBLE || probe_method_reg == PM_CUSTOM)
                        && (opcode == OP_INSERT || opcode == OP_REMOVE
                            || opcode == OP_SEARCH))
                       || (probe_method_reg == PM_ROBIN && opcode == OP_INSERT);
    assign no_free     = ~|free_in;
    assign rem_idx     = IDX_W'(red_rem);
    assign hash_mul    = hash_select_reg ? MUL_B : MUL_A;
    assign key_hit     = (rd_entry.key == key_reg) && (rd_entry.len == len_reg);
    assign slot_empty  = empty_reg[idx_reg];
    assign slot_tomb   = tomb_reg[idx_reg];
    assign lin_step    = mod_add(acc_lin_reg, lin_reg, n_size);
    assign sq_step     = mod_add(acc_sq_reg, sq_reg, n_size);
    assign sq2_step    = mod_add(sq_reg, sq2_reg, n_size);
    assign next_probe  = (probe_method_reg == PM_DOUBLE)
                         ? mod_add(idx_reg, step_reg, n_size)
                         : mod_add(mod_add(h_reg, lin_step, n_size), sq_step, n_size);
    assign next_linear = ((SIZE_W'(idx_reg) + 1'b1) == n_size) ? '0 : idx_reg + 1'b1;
    assign ins_addr    = have_tomb_reg ? tomb_idx_reg : idx_reg;

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        len_next        = len_reg;
        val_next        = val_reg;
        byte_idx_next   = byte_idx_reg;
        h_next          = h_reg;
        step_next       = step_reg;
        lin_next        = lin_reg;
        sq_next         = sq_reg;
        sq2_next        = sq2_reg;
        acc_lin_next    = acc_lin_reg;
        acc_sq_next     = acc_sq_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        tomb_idx_next   = tomb_idx_reg;
        have_tomb_next  = have_tomb_reg;
        seen_next       = seen_reg;
        displaced_next  = displaced_reg;
        full_next       = full_reg;
        dist_next       = dist_reg;
        empty_next      = empty_reg;
        tomb_next       = tomb_reg;
        coll_next       = coll_reg;
        fin_status_next = fin_status_reg;
        fin_probe_next  = fin_probe_reg;
        res_valid_next  = res_valid_reg && res_stall;
        res_status_next = res_status_reg;
        res_probe_next  = res_probe_reg;
        res_coll_next   = res_coll_reg;
        red_req         = '0;
        wr_addr         = idx_reg;
        we_entry        = 1'b0;
        we_dist         = 1'b0;
        wr_entry        = '{key: key_reg, len: len_reg, value: val_reg};
        wr_dist         = DIST_W'(dist_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next        = opcode;
                    key_next       = key_in;
                    len_next       = len_in;
                    val_next       = value;
                    byte_idx_next  = '0;
                    h_next         = '0;
                    fin_probe_next = '0;
                    if (!supported)
                    begin
                        fin_status_next = STAT_UNSUP;
                        state_next      = ST_FIN;
                    end
                    else
                    begin
                        phase_next = hash_select_reg ? PH_SEED : PH_BYTE;
                        state_next = ST_LAUNCH;
                    end
                end
            end

            ST_LAUNCH:
            begin
                red_req.start   = 1'b1;
                red_req.divisor = n_size;
                unique case (phase_reg)
                    PH_SEED:
                    begin
                        red_req.value = HASH_SEED;
                        red_req.shift = SH_SEED;
                    end
                    PH_BYTE:
                    begin
                        red_req.value = RED_W'(RED_W'(h_reg) * hash_mul)
                                        + RED_W'(key_reg[byte_idx_reg*8 +: 8]);
                        red_req.shift = SH_BYTE;
                    end
                    PH_STEP:
                    begin
                        red_req.value   = RED_W'(byte_sum);
                        red_req.divisor = n_size - 1'b1;
                        red_req.shift   = SH_STEP;
                    end
                    PH_LIN:
                    begin
                        red_req.value = RED_W'(RED_W'(linear_coeff_reg) * RED_W'(step_reg));
                        red_req.shift = SH_LIN;
                    end
                    PH_SQ:
                    begin
                        red_req.value = RED_W'(square_coeff_reg);
                        red_req.shift = SH_SQ;
                    end
                    default: ;
                endcase
                state_next = ST_WAIT;
            end

            ST_WAIT:
            begin
                if (red_done)
                begin
                    // defaults for starting the walk at the home slot
                    idx_next       = h_reg;
                    cnt_next       = '0;
                    have_tomb_next = 1'b0;
                    seen_next      = 1'b0;
                    displaced_next = 1'b0;
                    dist_next      = '0;
                    acc_lin_next   = '0;
                    acc_sq_next    = '0;
                    full_next      = no_free;
                    state_next     = ST_LAUNCH;
                    unique case (phase_reg)
                        PH_SEED:
                        begin
                            h_next     = rem_idx;
                            phase_next = PH_BYTE;
                        end
                        PH_BYTE:
                        begin
                            h_next   = rem_idx;
                            idx_next = rem_idx;
                            if (LEN_W'(byte_idx_reg) == len_reg - 1'b1)
                            begin
                                if (probe_method_reg == PM_ROBIN)
                                    state_next = ST_READ;
                                else
                                    phase_next = PH_STEP;
                            end
                            else
                            begin
                                byte_idx_next = byte_idx_reg + 1'b1;
                            end
                        end
                        PH_STEP:
                        begin
                            step_next = rem_idx + 1'b1;
                            if (probe_method_reg == PM_DOUBLE)
                                state_next = ST_READ;
                            else
                                phase_next = PH_LIN;
                        end
                        PH_LIN:
                        begin
                            lin_next   = rem_idx;
                            phase_next = PH_SQ;
                        end
                        PH_SQ:
                        begin
                            sq_next    = rem_idx;
                            sq2_next   = mod_add(rem_idx, rem_idx, n_size);
                            state_next = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end

            ST_READ:
            begin
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                fin_probe_next = '0;
                if (probe_method_reg == PM_ROBIN)
                begin
                    state_next = ST_READ;
                    if (dist_reg >= n_size)
                    begin
                        fin_status_next = STAT_FULL;
                        state_next      = ST_FIN;
                    end
                    else if (slot_empty || slot_tomb)
                    begin
                        we_entry               = 1'b1;
                        we_dist                = 1'b1;
                        empty_next[idx_reg]    = 1'b0;
                        tomb_next[idx_reg]     = 1'b0;
                        fin_status_next        = STAT_OK;
                        state_next             = ST_FIN;
                    end
                    else if (!displaced_reg && key_hit)
                    begin
                        fin_status_next = STAT_DUP;
                        state_next      = ST_FIN;
                    end
                    else
                    begin
                        if (!seen_reg)
                        begin
                            coll_next = coll_reg + 1'b1;
                            seen_next = 1'b1;
                        end
                        if (dist_reg > SIZE_W'(rd_dist))
                        begin
                            if (full_reg)
                            begin
                                fin_status_next = STAT_FULL;
                                state_next      = ST_FIN;
                            end
                            else
                            begin
                                // swap carried request with the richer resident
                                we_entry       = 1'b1;
                                we_dist        = 1'b1;
                                key_next       = rd_entry.key;
                                len_next       = rd_entry.len;
                                val_next       = rd_entry.value;
                                dist_next      = SIZE_W'(rd_dist) + 1'b1;
                                displaced_next = 1'b1;
                                idx_next       = next_linear;
                            end
                        end
                        else
                        begin
                            dist_next = dist_reg + 1'b1;
                            idx_next  = next_linear;
                        end
                    end
                end
                else if (slot_empty || cnt_reg == n_size)
                begin
                    state_next = ST_FIN;
                    if (op_reg == OP_INSERT)
                    begin
                        if (cnt_reg == n_size && !have_tomb_reg)
                        begin
                            fin_status_next = STAT_FULL;
                        end
                        else
                        begin
                            wr_addr              = ins_addr;
                            we_entry             = 1'b1;
                            empty_next[ins_addr] = 1'b0;
                            tomb_next[ins_addr]  = 1'b0;
                            fin_status_next      = STAT_OK;
                        end
                    end
                    else
                    begin
                        fin_status_next = STAT_MISS;
                        if (op_reg == OP_SEARCH)
                            fin_probe_next = cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next   = ST_READ;
                    cnt_next     = cnt_reg + 1'b1;
                    idx_next     = next_probe;
                    acc_lin_next = lin_step;
                    acc_sq_next  = sq_step;
                    sq_next      = sq2_step;
                    if (op_reg == OP_INSERT)
                    begin
                        if (slot_tomb)
                        begin
                            if (!have_tomb_reg)
                            begin
                                have_tomb_next = 1'b1;
                                tomb_idx_next  = idx_reg;
                            end
                        end
                        else if (key_hit)
                        begin
                            fin_status_next = STAT_DUP;
                            state_next      = ST_FIN;
                        end
                        else if (!seen_reg)
                        begin
                            coll_next = coll_reg + 1'b1;
                            seen_next = 1'b1;
                        end
                    end
                    else if (!slot_tomb && key_hit)
                    begin
                        if (op_reg == OP_REMOVE)
                            tomb_next[idx_reg] = 1'b1;
                        if (op_reg == OP_SEARCH)
                            fin_probe_next = cnt_reg + 1'b1;
                        fin_status_next = STAT_OK;
                        state_next      = ST_FIN;
                    end
                end
            end

            ST_FIN:
            begin
                // hold until the output register is free
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = fin_status_reg;
                    res_probe_next  = fin_probe_reg;
                    res_coll_next   = coll_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            empty_reg     <= '1;
            tomb_reg      <= '0;
            coll_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            empty_reg     <= empty_next;
            tomb_reg      <= tomb_next;
            coll_reg      <= coll_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg      <= phase_next;
        op_reg         <= op_next;
        key_reg        <= key_next;
        len_reg        <= len_next;
        val_reg        <= val_next;
        byte_idx_reg   <= byte_idx_next;
        h_reg          <= h_next;
        step_reg       <= step_next;
        lin_reg        <= lin_next;
        sq_reg         <= sq_next;
        sq2_reg        <= sq2_next;
        acc_lin_reg    <= acc_lin_next;
        acc_sq_reg     <= acc_sq_next;
        idx_reg        <= idx_next;
        cnt_reg        <= cnt_next;
        tomb_idx_reg   <= tomb_idx_next;
        have_tomb_reg  <= have_tomb_next;
        seen_reg       <= seen_next;
        displaced_reg  <= displaced_next;
        full_reg       <= full_next;
        dist_reg       <= dist_next;
        fin_status_reg <= fin_status_next;
        fin_probe_reg  <= fin_probe_next;
        res_status_reg <= res_status_next;
        res_probe_reg  <= res_probe_next;
        res_coll_reg   <= res_coll_next;
    end

    assign req_stall       = (state_reg != ST_IDLE);
    assign res_valid       = res_valid_reg;
    assign status          = res_status_reg;
    assign probe_count     = res_probe_reg;
    assign collision_total = res_coll_reg;

`ifndef SYNTHESIS
    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted without entering the walk");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state_reg == ST_FIN))
        else $error("result loaded outside the finish state");

    a_reduce_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        red_done |-> (state_reg == ST_WAIT))
        else $error("modulo unit finished while not awaited");

    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |-> (SIZE_W'(idx_reg) < n_size))
        else $error("probe slot beyond working table size");
`endif

endmodule
